FILE: hw/rtl/sequential_list_engine_macros.svh
// assertion macros shared by the list engine rtl
// expects clk and rst_n in the scope of each use
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sle_pkg.sv
// shared types and codes of the list engine
// no dependencies
package sle_pkg;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 3;
  localparam int LEN_W  = 7;

  // command codes
  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEL_POS = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_MIN = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_VAL = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_RNG = 3'd4;
  localparam logic [FUNC_W-1:0] FN_LIST    = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b000_0001,
    S_SHIFT_UP = 7'b000_0010,
    S_SHIFT_DN = 7'b000_0100,
    S_SCAN     = 7'b000_1000,
    S_COMPACT  = 7'b001_0000,
    S_LIST     = 7'b010_0000,
    S_DONE     = 7'b100_0000
  } sle_state_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
    logic             last;
  } sle_res_t;

endpackage

FILE: hw/rtl/sle_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sle_outq.sv
// two-entry result queue that decouples the sequencer from the result channel
// depends on sle_pkg
module sle_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sle_pkg::sle_res_t din,
  output logic            full,
  output logic [1:0]      cnt,
  output logic            out_valid,
  input  logic            out_ready,
  output sle_pkg::sle_res_t dout
);
  import sle_pkg::*;

  sle_res_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign cnt       = cnt_r;
  assign out_valid = (cnt_r != 2'd0);
  assign dout      = slot_r[rd_ptr_r];
  assign do_pop    = out_valid && out_ready;
  assign do_push   = push && !full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/sequential_list_engine.sv
// packed list of signed words kept in one ram, with a command sequencer on top
// depends on sle_pkg, sle_ram, sle_outq and sequential_list_engine_macros.svh
// a command walks the ram (shift, scan or compaction) and then queues its result, rejected commands
// go straight to their result, and list queues one entry per cycle while the result queue has room
// one command at a time: no new command is taken until the last one has queued its result
// reset: rst_n synchronous active low, clears length and control; ram is not cleared
module sequential_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: position [6:0], operand_value [38:7], upper_bound [70:39], zero pad [71]
  input  logic [71:0] in_tdata,
  // tuser: func [2:0]
  input  logic [2:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: result_value [31:0], list_length [38:32], zero pad [39]
  output logic [39:0] out_tdata,
  // tuser: status [2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);
  import sle_pkg::*;

  `include "sequential_list_engine_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // compare width wide enough for both position and length plus one
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // command fields
  logic [FUNC_W-1:0]       in_func;
  logic [POS_W-1:0]        in_pos;
  logic signed [VAL_W-1:0] in_opnd;
  logic signed [VAL_W-1:0] in_upper;
  logic                    in_acc;

  assign in_func  = in_tuser[2:0];
  assign in_pos   = in_tdata[6:0];
  assign in_opnd  = in_tdata[38:7];
  assign in_upper = in_tdata[70:39];

  // control state
  sle_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;     // next read index (shift up: index plus one)
  logic [CW-1:0] k_r, k_nxt;         // compaction write index
  logic          rvld_r, rvld_nxt;   // ram read data returns this cycle
  logic          rcap_r, rcap_nxt;   // returning word is the removed entry
  logic          first_r, first_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  // payload state
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] hi_r, hi_nxt;
  logic                    mode_r, mode_nxt;   // 1 range match, 0 equal match
  logic [ST_W-1:0]         status_r, status_nxt;
  logic [VAL_W-1:0]        result_r, result_nxt;
  logic [AW-1:0]           wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]           ridx_r, ridx_nxt;
  logic signed [VAL_W-1:0] min_val_r, min_val_nxt;
  logic [AW-1:0]           min_idx_r, min_idx_nxt;
  logic [VAL_W-1:0]        last_val_r, last_val_nxt;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic             rd_issue;

  // result queue
  logic       q_push, q_full, q_pop;
  logic [1:0] q_cnt;
  logic [2:0] q_occ;
  sle_res_t   q_din, q_dout;

  // compare helpers
  logic [XW-1:0]           pos_x, cnt_x;
  logic signed [VAL_W-1:0] rd_s;
  logic                    drop;

  assign pos_x = XW'(in_pos);
  assign cnt_x = XW'(count_r);
  assign rd_s  = $signed(ram_rdata);
  assign drop  = mode_r ? ((rd_s >= val_r) && (rd_s <= hi_r)) : (rd_s == val_r);

  // queue slots committed once the word in flight lands
  assign q_pop = out_tvalid && out_tready;
  assign q_occ = 3'(q_cnt) + 3'(rvld_r) - 3'(q_pop);

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sle_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .cnt       (q_cnt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dout      (q_dout)
  );

  assign out_tdata = {1'b0, q_dout.length, q_dout.value};
  assign out_tuser = q_dout.status;
  assign out_tlast = q_dout.last;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    k_nxt        = k_r;
    rvld_nxt     = 1'b0;
    rcap_nxt     = 1'b0;
    first_nxt    = first_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    hi_nxt       = hi_r;
    mode_nxt     = mode_r;
    status_nxt   = status_r;
    result_nxt   = result_r;
    wr_addr_nxt  = wr_addr_r;
    ridx_nxt     = ridx_r;
    min_val_nxt  = min_val_r;
    min_idx_nxt  = min_idx_r;
    last_val_nxt = last_val_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    rd_issue     = 1'b0;
    q_push       = 1'b0;
    q_din        = '0;

    // returning read data, handled per command
    if (rvld_r) begin
      case (state_r) inside
        S_SHIFT_UP, S_SHIFT_DN: begin
          if (rcap_r) begin
            result_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_r;
            ram_wdata = ram_rdata;
          end
        end
        S_SCAN: begin
          // strict less keeps the first smallest entry
          if (ridx_r == '0 || rd_s < min_val_r) begin
            min_val_nxt = rd_s;
            min_idx_nxt = ridx_r;
          end
          last_val_nxt = ram_rdata;
        end
        S_COMPACT: begin
          if (!drop) begin
            ram_we    = 1'b1;
            ram_waddr = k_r[AW-1:0];
            ram_wdata = ram_rdata;
            k_nxt     = k_r + 1'b1;
          end
        end
        S_LIST: begin
          q_push       = 1'b1;
          q_din.status = ST_OK;
          q_din.value  = ram_rdata;
          q_din.length = LEN_W'(count_r);
          q_din.last   = (ridx_r == AW'(count_r - 1'b1));
        end
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_nxt    = in_pos;
          val_nxt    = in_opnd;
          hi_nxt     = in_upper;
          mode_nxt   = (in_func == FN_DEL_RNG);
          status_nxt = ST_OK;
          result_nxt = '0;
          ptr_nxt    = '0;
          k_nxt      = '0;
          first_nxt  = 1'b1;
          state_nxt  = S_DONE;
          unique case (in_func)
            FN_INSERT: begin
              if (in_pos == '0 || pos_x > cnt_x + XW'(1)) begin
                status_nxt = ST_BADPOS;
              end else if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            FN_DEL_POS: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (in_pos == '0 || pos_x > cnt_x) begin
                status_nxt = ST_BADPOS;
              end else begin
                ptr_nxt   = CW'(in_pos - 1'b1);
                state_nxt = S_SHIFT_DN;
              end
            end
            FN_DEL_MIN: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_DEL_VAL: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_COMPACT;
              end
            end
            FN_DEL_RNG: begin
              // inverted range wins over an empty list
              if (in_opnd > in_upper) begin
                status_nxt = ST_RANGE;
              end else if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_COMPACT;
              end
            end
            FN_LIST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: ;  // unused codes answer ok and change nothing
          endcase
        end
      end

      S_SHIFT_UP: begin
        // walk from the tail down to the insert slot, each word moves up one
        if (XW'(ptr_r) >= XW'(pos_r)) begin
          rd_issue    = 1'b1;
          ram_raddr   = AW'(ptr_r - 1'b1);
          wr_addr_nxt = ptr_r[AW-1:0];
          rvld_nxt    = 1'b1;
          ptr_nxt     = ptr_r - 1'b1;
        end else if (!rvld_r) begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(pos_r - 1'b1);
          ram_wdata  = val_r;
          count_nxt  = count_r + 1'b1;
          state_nxt  = S_DONE;
        end
      end

      S_SHIFT_DN: begin
        // first read captures the removed word, the rest move down one
        if (ptr_r < count_r) begin
          rd_issue    = 1'b1;
          ram_raddr   = ptr_r[AW-1:0];
          wr_addr_nxt = AW'(ptr_r - 1'b1);
          rvld_nxt    = 1'b1;
          rcap_nxt    = first_r;
          first_nxt   = 1'b0;
          ptr_nxt     = ptr_r + 1'b1;
        end else if (!rvld_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        if (ptr_r < count_r) begin
          rd_issue  = 1'b1;
          ram_raddr = ptr_r[AW-1:0];
          ridx_nxt  = ptr_r[AW-1:0];
          rvld_nxt  = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
        end else if (!rvld_r) begin
          // tail word refills the hole left by the minimum
          ram_we     = 1'b1;
          ram_waddr  = min_idx_r;
          ram_wdata  = last_val_r;
          result_nxt = min_val_r;
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_DONE;
        end
      end

      S_COMPACT: begin
        if (ptr_r < count_r) begin
          rd_issue  = 1'b1;
          ram_raddr = ptr_r[AW-1:0];
          rvld_nxt  = 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
        end else if (!rvld_r) begin
          count_nxt = k_r;
          state_nxt = S_DONE;
        end
      end

      S_LIST: begin
        // read only when a queue slot is sure to be free on return
        if (ptr_r < count_r) begin
          if (q_occ < 3'd2) begin
            rd_issue  = 1'b1;
            ram_raddr = ptr_r[AW-1:0];
            ridx_nxt  = ptr_r[AW-1:0];
            rvld_nxt  = 1'b1;
            ptr_nxt   = ptr_r + 1'b1;
          end
        end else if (!rvld_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_DONE: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_din.status = status_r;
          q_din.value  = result_r;
          q_din.length = LEN_W'(count_r);
          q_din.last   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      k_r     <= '0;
      rvld_r  <= 1'b0;
      rcap_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      k_r     <= k_nxt;
      rvld_r  <= rvld_nxt;
      rcap_r  <= rcap_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    hi_r       <= hi_nxt;
    mode_r     <= mode_nxt;
    status_r   <= status_nxt;
    result_r   <= result_nxt;
    wr_addr_r  <= wr_addr_nxt;
    ridx_r     <= ridx_nxt;
    min_val_r  <= min_val_nxt;
    min_idx_r  <= min_idx_nxt;
    last_val_r <= last_val_nxt;
  end

  // length never passes capacity
  `SLE_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CW'(CAPACITY), "length above capacity")
  // a write never lands on the word being fetched in the same cycle
  `SLE_ASSERT_IMP(a_no_rw_hit, ram_we && rd_issue, ram_waddr != ram_raddr,
                  "ram read and write collide")
  // read credit keeps the result queue from overflowing
  `SLE_ASSERT_IMP(a_q_room, q_push, !q_full, "result pushed into full queue")
  // length only moves while a command runs
  `SLE_ASSERT_NXT(a_idle_len, state_r == S_IDLE, count_r == $past(count_r),
                  "length changed while idle")

endmodule
